FILE: rtl/md5_block_compress_unit_assert.svh
// assertion macros for the md5 block compression unit
`ifndef MD5_BLOCK_COMPRESS_UNIT_ASSERT_SVH
`define MD5_BLOCK_COMPRESS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MD5BC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5bc check failed");

// next-cycle implication, sampled on clk, off during reset
`define MD5BC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5bc check failed");

`endif

FILE: rtl/md5bc_pkg.sv
// types, constants, round tables and microcode for the md5 block compression unit
`timescale 1ns / 1ps
package md5bc_pkg;

    typedef struct packed {
        logic        opcode;
        logic [31:0] data_word;
    } md5bc_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5bc_out_t;

    localparam logic OPC_MSG  = 1'b0;
    localparam logic OPC_LOAD = 1'b1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // micro-operations
    localparam logic [2:0] UOP_WAIT  = 3'd0;
    localparam logic [2:0] UOP_INIT  = 3'd1;
    localparam logic [2:0] UOP_ROUND = 3'd2;
    localparam logic [2:0] UOP_ADD   = 3'd3;
    localparam logic [2:0] UOP_EMIT  = 3'd4;

    // jump conditions
    localparam logic [1:0] COND_NEVER      = 2'd0;
    localparam logic [1:0] COND_ALWAYS     = 2'd1;
    localparam logic [1:0] COND_NOT_GO     = 2'd2;
    localparam logic [1:0] COND_ROUND_MORE = 2'd3;

    // program steps
    localparam logic [2:0] STEP_WAIT  = 3'd0;
    localparam logic [2:0] STEP_INIT  = 3'd1;
    localparam logic [2:0] STEP_ROUND = 3'd2;
    localparam logic [2:0] STEP_ADD   = 3'd3;
    localparam logic [2:0] STEP_EMIT0 = 3'd4;
    localparam logic [2:0] STEP_EMIT1 = 3'd5;
    localparam logic [2:0] STEP_EMIT2 = 3'd6;
    localparam logic [2:0] STEP_EMIT3 = 3'd7;

    typedef struct packed {
        logic [2:0] uop;
        logic [1:0] cond;
        logic [2:0] target;
        logic [1:0] widx;
        logic       last;
    } md5bc_uword_t;

    typedef struct packed {
        logic [2:0] uop;
        logic [1:0] widx;
        logic       last;
        logic [5:0] round;
        logic [5:0] pre_round;
    } md5bc_ctrl_t;

    function automatic md5bc_uword_t md5bc_ucode(input logic [2:0] step);
        md5bc_uword_t w;
        w = '{uop: UOP_WAIT, cond: COND_NOT_GO, target: STEP_WAIT, widx: 2'd0, last: 1'b0};
        unique case (step)
            STEP_WAIT:  w = '{UOP_WAIT,  COND_NOT_GO,     STEP_WAIT,  2'd0, 1'b0};
            STEP_INIT:  w = '{UOP_INIT,  COND_NEVER,      STEP_WAIT,  2'd0, 1'b0};
            STEP_ROUND: w = '{UOP_ROUND, COND_ROUND_MORE, STEP_ROUND, 2'd0, 1'b0};
            STEP_ADD:   w = '{UOP_ADD,   COND_NEVER,      STEP_WAIT,  2'd0, 1'b0};
            STEP_EMIT0: w = '{UOP_EMIT,  COND_NEVER,      STEP_WAIT,  2'd0, 1'b0};
            STEP_EMIT1: w = '{UOP_EMIT,  COND_NEVER,      STEP_WAIT,  2'd1, 1'b0};
            STEP_EMIT2: w = '{UOP_EMIT,  COND_NEVER,      STEP_WAIT,  2'd2, 1'b0};
            STEP_EMIT3: w = '{UOP_EMIT,  COND_ALWAYS,     STEP_WAIT,  2'd3, 1'b1};
            default:    w = '{UOP_WAIT,  COND_NOT_GO,     STEP_WAIT,  2'd0, 1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] md5bc_round_const(input logic [5:0] i);
        logic [31:0] k;
        k = 32'h0;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5bc_rot_amount(input logic [5:0] i);
        logic [4:0] s;
        s = 5'd0;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message schedule: which buffered word a round reads
    function automatic logic [3:0] md5bc_msg_index(input logic [5:0] i);
        logic [3:0] lo;
        logic [3:0] g;
        lo = i[3:0];
        g  = lo;
        case (i[5:4])
            2'd0: g = lo;
            2'd1: g = 4'(lo + (lo << 2) + 4'd1);
            2'd2: g = 4'(lo + (lo << 1) + 4'd5);
            2'd3: g = 4'((lo << 3) - lo);
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/md5bc_seq.sv
// microcode sequencer: step counter, program table and round counter
`timescale 1ns / 1ps
module md5bc_seq
    import md5bc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    output logic        busy,
    output md5bc_ctrl_t ctrl
);

    logic [2:0]   pc_reg;
    logic [2:0]   pc_next;
    logic [5:0]   round_reg;
    logic [5:0]   round_next;
    md5bc_uword_t uw;
    logic         take;

    assign uw = md5bc_ucode(pc_reg);

    always_comb
    begin
        take = 1'b0;
        unique case (uw.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_NOT_GO:     take = !go;
            COND_ROUND_MORE: take = !(&round_reg);
            default:         take = 1'b0;
        endcase
        pc_next = take ? uw.target : 3'(pc_reg + 3'd1);
    end

    always_comb
    begin
        round_next = round_reg;
        if (uw.uop == UOP_INIT)
        begin
            round_next = 6'd0;
        end
        else if (uw.uop == UOP_ROUND)
        begin
            round_next = 6'(round_reg + 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= STEP_WAIT;
            round_reg <= 6'd0;
        end
        else
        begin
            pc_reg    <= pc_next;
            round_reg <= round_next;
        end
    end

    assign busy           = (pc_reg != STEP_WAIT);
    assign ctrl.uop       = uw.uop;
    assign ctrl.widx      = uw.widx;
    assign ctrl.last      = uw.last;
    assign ctrl.round     = round_reg;
    assign ctrl.pre_round = (uw.uop == UOP_INIT) ? 6'd0 : 6'(round_reg + 6'd1);

endmodule

FILE: rtl/md5bc_datapath.sv
// md5 datapath: chaining words, message buffer, round unit and result register
`timescale 1ns / 1ps
module md5bc_datapath
    import md5bc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  md5bc_in_t   cmd,
    input  md5bc_ctrl_t ctrl,
    output logic        block_full,
    output logic        result_strobe,
    output md5bc_out_t  result
);

    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] msg_reg [16];
    logic [3:0]  msg_count_reg;
    logic [1:0]  load_idx_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] t_reg;
    logic [31:0] t_next;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [63:0] rot_wide;
    logic [31:0] b_new;
    logic        strobe_reg;
    md5bc_out_t  out_reg;

    assign block_full = &msg_count_reg;

    // round function
    always_comb
    begin
        f_val = 32'h0;
        case (ctrl.round[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = 32'h0;
        endcase
        sum_val  = a_reg + f_val + t_reg;
        rot_wide = {sum_val, sum_val} << md5bc_rot_amount(ctrl.round);
        b_new    = b_reg + rot_wide[63:32];
        // constant plus message word for the following round
        t_next   = md5bc_round_const(ctrl.pre_round) + msg_reg[md5bc_msg_index(ctrl.pre_round)];
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            chain_next[k] = chain_reg[k];
        end
        if (accept && cmd.opcode == OPC_LOAD)
        begin
            chain_next[load_idx_reg] = cmd.data_word;
        end
        else if (ctrl.uop == UOP_ADD)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
            msg_count_reg <= 4'd0;
            load_idx_reg  <= 2'd0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
            if (accept && cmd.opcode == OPC_LOAD)
            begin
                load_idx_reg <= 2'(load_idx_reg + 2'd1);
            end
            if (accept && cmd.opcode == OPC_MSG)
            begin
                msg_count_reg <= 4'(msg_count_reg + 4'd1);
            end
            strobe_reg <= (ctrl.uop == UOP_EMIT);
        end
    end

    // message buffer, no reset
    always_ff @(posedge clk)
    begin
        if (accept && cmd.opcode == OPC_MSG)
        begin
            msg_reg[msg_count_reg] <= cmd.data_word;
        end
    end

    // working words and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.uop == UOP_INIT)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            t_reg <= t_next;
        end
        else if (ctrl.uop == UOP_ROUND)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
            t_reg <= t_next;
        end
        if (ctrl.uop == UOP_EMIT)
        begin
            out_reg.digest_word <= chain_reg[ctrl.widx];
            out_reg.word_index  <= ctrl.widx;
            out_reg.last_word   <= ctrl.last;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = out_reg;

endmodule

FILE: rtl/md5_block_compress_unit.sv
// top level of the md5 block compression unit
`timescale 1ns / 1ps
// A word is taken on a clock edge where start is high and busy is low. Chaining
// loads and the first fifteen message words of a block give no result and keep
// busy low. The sixteenth message word starts a run of the microcode sequencer:
// one setup step, 64 rounds at one per cycle on the single round unit, one add
// step and four result steps. The four results carry result_strobe high, with
// A first and D marked by last_word; the receiver cannot stall them. busy stays
// high while the sequencer runs these steps, so no word is taken meanwhile.
`include "md5_block_compress_unit_assert.svh"
module md5_block_compress_unit
    import md5bc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  md5bc_in_t  cmd,
    output logic       busy,
    output logic       result_strobe,
    output md5bc_out_t result
);

    logic        accept;
    logic        block_full;
    logic        go;
    md5bc_ctrl_t ctrl;

    assign accept = start && !busy;
    assign go     = accept && (cmd.opcode == OPC_MSG) && block_full;

    md5bc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    md5bc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .ctrl          (ctrl),
        .block_full    (block_full),
        .result_strobe (result_strobe),
        .result        (result)
    );

    `MD5BC_ASSERT_NEXT(a_go_busy, go, busy)
    `MD5BC_ASSERT_NEXT(a_load_no_run, accept && cmd.opcode == OPC_LOAD, !busy)
    `MD5BC_ASSERT_NEXT(a_last_ends, result_strobe && result.last_word, !result_strobe)
    `MD5BC_ASSERT_NEXT(a_words_in_order, result_strobe && !result.last_word,
        result_strobe && result.word_index == 2'($past(result.word_index) + 2'd1))
    `MD5BC_ASSERT_NOW(a_last_is_d, result_strobe && result.last_word,
        result.word_index == 2'd3)

endmodule
